FILE: hdl/ocdra_pkg.sv
// Shared types, opcodes and constants for the OLED command decoder.
package ocdra_pkg;

  localparam int COLUMNS = 128;
  localparam int ROWS    = 64;
  localparam int PAGES   = ROWS / 8;

  localparam logic [6:0] COL_HI_FULL  = 7'(COLUMNS - 1);
  localparam logic [2:0] PAGE_HI_FULL = 3'(PAGES - 1);
  localparam logic [7:0] COL_LIMIT    = 8'(COLUMNS);
  localparam logic [3:0] PAGE_LIMIT   = 4'(PAGES);

  // Addressing modes
  localparam logic [1:0] MODE_HORIZ = 2'd0;
  localparam logic [1:0] MODE_VERT  = 2'd1;
  localparam logic [1:0] MODE_PAGE  = 2'd2;

  // Fault codes
  localparam logic [1:0] FAULT_NONE    = 2'd0;
  localparam logic [1:0] FAULT_UNKNOWN = 2'd1;
  localparam logic [1:0] FAULT_PARAM   = 2'd2;

  // Opcodes that act on their parameters
  localparam logic [7:0] OP_ADDR_MODE   = 8'h20;
  localparam logic [7:0] OP_COL_WINDOW  = 8'h21;
  localparam logic [7:0] OP_PAGE_WINDOW = 8'h22;
  localparam logic [7:0] OP_OFFSET      = 8'hD3;

  // Multi-byte opcodes whose parameters are only consumed.
  localparam logic [7:0] OP_CONTRAST     = 8'h81;
  localparam logic [7:0] OP_CHARGE_PUMP  = 8'h8D;
  localparam logic [7:0] OP_MUX_RATIO    = 8'hA8;
  localparam logic [7:0] OP_CLOCK_DIV    = 8'hD5;
  localparam logic [7:0] OP_PRECHARGE    = 8'hD9;
  localparam logic [7:0] OP_COM_PINS     = 8'hDA;
  localparam logic [7:0] OP_VCOMH        = 8'hDB;
  localparam logic [7:0] OP_VSCROLL_AREA = 8'hA3;
  localparam logic [7:0] OP_VH_SCROLL_R  = 8'h29;
  localparam logic [7:0] OP_VH_SCROLL_L  = 8'h2A;
  localparam logic [7:0] OP_H_SCROLL_R   = 8'h26;
  localparam logic [7:0] OP_H_SCROLL_L   = 8'h27;

  // Bases of the opcode ranges that carry their argument in the low bits.
  localparam logic [7:0] OP_COL_NIB_LO = 8'h00;
  localparam logic [7:0] OP_COL_NIB_HI = 8'h10;
  localparam logic [7:0] OP_START_LINE = 8'h40;
  localparam logic [7:0] OP_PAGE_SET   = 8'hB0;

  // Single-byte opcodes with an effect
  localparam logic [7:0] OP_REMAP_OFF = 8'hA0;
  localparam logic [7:0] OP_REMAP_ON  = 8'hA1;
  localparam logic [7:0] OP_FORCE_OFF = 8'hA4;
  localparam logic [7:0] OP_FORCE_ON  = 8'hA5;
  localparam logic [7:0] OP_DISP_OFF  = 8'hAE;
  localparam logic [7:0] OP_DISP_ON   = 8'hAF;

  // Single-byte opcodes accepted without effect
  localparam logic [7:0] OP_SCROLL_OFF = 8'h2E;
  localparam logic [7:0] OP_SCROLL_ON  = 8'h2F;
  localparam logic [7:0] OP_NORMAL     = 8'hA6;
  localparam logic [7:0] OP_INVERT     = 8'hA7;
  localparam logic [7:0] OP_COM_NORMAL = 8'hC0;
  localparam logic [7:0] OP_COM_REMAP  = 8'hC8;
  localparam logic [7:0] OP_NOP        = 8'hE3;

  typedef struct packed {
    logic       is_data;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic       wr_valid;
    logic [6:0] wr_column;
    logic [2:0] wr_page;
    logic [7:0] wr_pixels;
    logic       panel_on;
    logic       all_lit;
    logic [5:0] first_line;
    logic [7:0] vert_offset;
    logic       mirror_columns;
    logic [1:0] fault;
  } out_t;

  typedef struct packed {
    logic [6:0] col_ptr;
    logic [2:0] page_ptr;
    logic [6:0] col_lo;
    logic [6:0] col_hi;
    logic [2:0] page_lo;
    logic [2:0] page_hi;
    logic [1:0] addr_mode;
    logic [7:0] pending_opcode;
    logic [2:0] params_left;
    logic [2:0] param_index;
    logic       on_flag;
    logic       force_flag;
    logic [5:0] start_line;
    logic [7:0] offset;
    logic       remap_flag;
  } state_t;

  localparam state_t STATE_RESET = '{
    col_ptr:        7'd0,
    page_ptr:       3'd0,
    col_lo:         7'd0,
    col_hi:         7'd127,
    page_lo:        3'd0,
    page_hi:        3'd7,
    addr_mode:      MODE_PAGE,
    pending_opcode: 8'd0,
    params_left:    3'd0,
    param_index:    3'd0,
    on_flag:        1'b0,
    force_flag:     1'b0,
    start_line:     6'd0,
    offset:         8'd0,
    remap_flag:     1'b0
  };

  // Number of parameter bytes that follow a multi-byte opcode.
  function automatic logic [2:0] param_count(input logic [7:0] op);
    logic [2:0] n;
    n = 3'd0;
    unique case (op)
      OP_ADDR_MODE, OP_CONTRAST, OP_CHARGE_PUMP, OP_MUX_RATIO, OP_OFFSET,
      OP_CLOCK_DIV, OP_PRECHARGE, OP_COM_PINS, OP_VCOMH: n = 3'd1;
      OP_COL_WINDOW, OP_PAGE_WINDOW, OP_VSCROLL_AREA:    n = 3'd2;
      OP_VH_SCROLL_R, OP_VH_SCROLL_L:                    n = 3'd5;
      OP_H_SCROLL_R, OP_H_SCROLL_L:                      n = 3'd6;
      default:                                           n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

FILE: hdl/ocdra_decode.sv
// Per-item decode: next controller state and the result item.
module ocdra_decode (
  input  ocdra_pkg::state_t st,
  input  ocdra_pkg::in_t    item,
  output ocdra_pkg::state_t st_nxt,
  output ocdra_pkg::out_t   res
);

  logic [7:0] pval;
  logic [7:0] byte_v;
  logic [2:0] pcount;
  logic [7:0] c_inc;
  logic [3:0] p_inc;
  logic       c_wrap;
  logic       p_wrap;
  logic [1:0] fault;
  logic       wv;

  assign byte_v = item.data_byte;
  assign pcount = ocdra_pkg::param_count(byte_v);
  // A data byte in a parameter slot counts as zero.
  assign pval   = item.is_data ? 8'd0 : byte_v;

  assign c_inc  = {1'b0, st.col_ptr} + 8'd1;
  assign p_inc  = {1'b0, st.page_ptr} + 4'd1;
  assign c_wrap = c_inc > {1'b0, st.col_hi};
  assign p_wrap = p_inc > {1'b0, st.page_hi};

  always_comb begin
    st_nxt = st;
    fault  = ocdra_pkg::FAULT_NONE;
    wv     = 1'b0;
    res    = '0;

    if (st.params_left != 3'd0) begin
      if (item.is_data) begin
        fault = ocdra_pkg::FAULT_PARAM;
      end
      unique case (st.pending_opcode)
        ocdra_pkg::OP_ADDR_MODE: begin
          st_nxt.addr_mode = pval[1:0];
          st_nxt.page_ptr  = 3'd0;
          st_nxt.page_lo   = 3'd0;
          st_nxt.page_hi   = ocdra_pkg::PAGE_HI_FULL;
          st_nxt.col_ptr   = 7'd0;
          st_nxt.col_lo    = 7'd0;
          st_nxt.col_hi    = ocdra_pkg::COL_HI_FULL;
        end
        ocdra_pkg::OP_COL_WINDOW: begin
          if (st.param_index == 3'd0) begin
            st_nxt.col_lo = pval[6:0];
          end else begin
            st_nxt.col_hi  = pval[6:0];
            st_nxt.col_ptr = st.col_lo;
          end
        end
        ocdra_pkg::OP_PAGE_WINDOW: begin
          if (st.param_index == 3'd0) begin
            st_nxt.page_lo = pval[2:0];
          end else begin
            st_nxt.page_hi  = pval[2:0];
            st_nxt.page_ptr = st.page_lo;
          end
        end
        ocdra_pkg::OP_OFFSET: begin
          st_nxt.offset = pval;
        end
        default: begin
        end
      endcase
      st_nxt.param_index = st.param_index + 3'd1;
      st_nxt.params_left = st.params_left - 3'd1;
    end else if (item.is_data) begin
      if ({1'b0, st.col_ptr} < ocdra_pkg::COL_LIMIT &&
          {1'b0, st.page_ptr} < ocdra_pkg::PAGE_LIMIT) begin
        wv = 1'b1;
        res.wr_column = st.col_ptr;
        res.wr_page   = st.page_ptr;
        res.wr_pixels = byte_v;
      end
      // Pointer advance; mode 3 behaves as page mode.
      if (st.addr_mode == ocdra_pkg::MODE_HORIZ) begin
        if (c_wrap) begin
          st_nxt.col_ptr  = st.col_lo;
          st_nxt.page_ptr = p_wrap ? st.page_lo : p_inc[2:0];
        end else begin
          st_nxt.col_ptr = c_inc[6:0];
        end
      end else if (st.addr_mode == ocdra_pkg::MODE_VERT) begin
        if (p_wrap) begin
          st_nxt.page_ptr = st.page_lo;
          st_nxt.col_ptr  = c_wrap ? st.col_lo : c_inc[6:0];
        end else begin
          st_nxt.page_ptr = p_inc[2:0];
        end
      end else begin
        st_nxt.col_ptr = c_wrap ? st.col_lo : c_inc[6:0];
      end
    end else begin
      priority if (byte_v[7:4] == ocdra_pkg::OP_COL_NIB_LO[7:4]) begin
        st_nxt.col_lo  = {st.col_lo[6:4], byte_v[3:0]};
        st_nxt.col_ptr = {st.col_lo[6:4], byte_v[3:0]};
      end else if (byte_v[7:4] == ocdra_pkg::OP_COL_NIB_HI[7:4]) begin
        st_nxt.col_lo  = {byte_v[2:0], st.col_lo[3:0]};
        st_nxt.col_ptr = {byte_v[2:0], st.col_lo[3:0]};
      end else if (byte_v[7:6] == ocdra_pkg::OP_START_LINE[7:6]) begin
        st_nxt.start_line = byte_v[5:0];
      end else if (byte_v[7:3] == ocdra_pkg::OP_PAGE_SET[7:3]) begin
        st_nxt.page_ptr = byte_v[2:0];
      end else if (pcount != 3'd0) begin
        st_nxt.pending_opcode = byte_v;
        st_nxt.params_left    = pcount;
        st_nxt.param_index    = 3'd0;
      end else begin
        unique case (byte_v)
          ocdra_pkg::OP_SCROLL_OFF, ocdra_pkg::OP_SCROLL_ON, ocdra_pkg::OP_NORMAL,
          ocdra_pkg::OP_INVERT, ocdra_pkg::OP_COM_NORMAL, ocdra_pkg::OP_COM_REMAP,
          ocdra_pkg::OP_NOP: begin
          end
          ocdra_pkg::OP_REMAP_OFF: st_nxt.remap_flag = 1'b0;
          ocdra_pkg::OP_REMAP_ON:  st_nxt.remap_flag = 1'b1;
          ocdra_pkg::OP_FORCE_OFF: st_nxt.force_flag = 1'b0;
          ocdra_pkg::OP_FORCE_ON:  st_nxt.force_flag = 1'b1;
          ocdra_pkg::OP_DISP_OFF:  st_nxt.on_flag    = 1'b0;
          ocdra_pkg::OP_DISP_ON:   st_nxt.on_flag    = 1'b1;
          default:                 fault = ocdra_pkg::FAULT_UNKNOWN;
        endcase
      end
    end

    res.wr_valid       = wv;
    res.panel_on       = st_nxt.on_flag;
    res.all_lit        = st_nxt.force_flag;
    res.first_line     = st_nxt.start_line;
    res.vert_offset    = st_nxt.offset;
    res.mirror_columns = st_nxt.remap_flag;
    res.fault          = fault;
  end

endmodule

FILE: hdl/oled_command_decoder_ram_addressing.sv
// OLED controller command decoder and display-RAM address generator.
// The result item is registered and appears in the cycle after its input item is accepted.
// It takes one item per cycle while out_ready lets the held result leave; the decode
// is a single pass of logic between the state registers and the result register.
// Reset (rst_n low, synchronous) restores page mode, the full windows, zeroed
// pointers and flags, and empties the result register.
module oled_command_decoder_ram_addressing (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  ocdra_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output ocdra_pkg::out_t out_data
);

  ocdra_pkg::state_t state_r;
  ocdra_pkg::state_t state_nxt;
  ocdra_pkg::out_t   res_r;
  ocdra_pkg::out_t   res_nxt;
  logic              res_valid_r;
  logic              accept;

  ocdra_decode u_decode (
    .st     (state_r),
    .item   (in_data),
    .st_nxt (state_nxt),
    .res    (res_nxt)
  );

  // A new item may enter whenever no result is held or the held result leaves in the same cycle.
  assign in_ready  = !res_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = res_valid_r;
  assign out_data  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ocdra_pkg::STATE_RESET;
      res_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        state_r     <= state_nxt;
        res_valid_r <= 1'b1;
      end else if (out_ready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

endmodule
